### rtl/assert_macros.svh
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen at a rising edge outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/mwbg_pkg.sv
// constants, register codes and exponential table builder for the morlet bin generator
package mwbg_pkg;

	// parameter defaults
	localparam int INDEX_BITS_DEFAULT      = 16;
	localparam int EXP_TABLE_DEPTH_DEFAULT = 256;

	// configuration port shape
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 40;

	// register widths
	localparam int LENGTH_W = 17;
	localparam int STEP_W   = 32;
	localparam int SCALE_W  = 32;
	localparam int OMEGA_W  = 24;
	localparam int NORM_W   = 32;
	localparam int PHYS_W   = 40;

	// register reset values
	localparam logic [LENGTH_W-1:0] LENGTH_RESET = 17'd1024;
	localparam logic [STEP_W-1:0]   STEP_RESET   = 32'd3294199;
	localparam logic [SCALE_W-1:0]  SCALE_RESET  = 32'd65536;
	localparam logic [OMEGA_W-1:0]  OMEGA_RESET  = 24'd393216;
	localparam logic [NORM_W-1:0]   NORM_RESET   = 32'd49225;
	localparam logic [PHYS_W-1:0]   PHYS_RESET   = 40'd402;

	// payload widths
	localparam int BIN_W   = 16;
	localparam int VALUE_W = 32;
	localparam int DERIV_W = 48;

	// distance from center in q.16 beyond which the exponential is zero (8.0)
	localparam int NEAR_BITS = 19;
	// derivative magnitude limit, 2^47
	localparam logic [DERIV_W-1:0] DERIV_LIMIT = 48'h8000_0000_0000;

	// exponential table entry, q0.32 with one extra bit for the value one
	localparam int EXP_W = 33;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_LENGTH_N     = 3'd0,
		REG_BIN_STEP     = 3'd1,
		REG_SCALE_VALUE  = 3'd2,
		REG_CENTER_OMEGA = 3'd3,
		REG_NORM_GAIN    = 3'd4,
		REG_PHYS_STEP    = 3'd5
	} cfg_reg_t;

	// (a*b) >> 60 with round half up, low 64 bits kept
	function automatic logic [63:0] mul_shift60(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] prod;
		prod = {64'd0, a} * {64'd0, b} + (128'd1 << 59);
		return prod[123:60];
	endfunction

	// exp(-64*y) for y in q.60: taylor series of exp(-y), squared six times, then q0.32
	function automatic logic [EXP_W-1:0] exp_rom_entry(input logic [63:0] y);
		logic [63:0] sum;
		logic [63:0] term;
		logic [63:0] rnd;
		int n;
		sum  = 64'd1 << 60;
		term = 64'd1 << 60;
		for (n = 1; n <= 24; n++) begin
			term = mul_shift60(term, y) / 64'(n);
			if (n[0]) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		for (n = 0; n < 6; n++) begin
			sum = mul_shift60(sum, sum);
		end
		rnd = sum + (64'd1 << 27);
		return rnd[60:28];
	endfunction

endpackage

### rtl/morlet_wavelet_bin_generator.sv
// top level: fully pipelined analytic morlet wavelet bin generator
// One bin index enters per clock unless in_stall is high, and its wavelet value
// and derivative leave from the last stage, sustained at one bin per clock while
// the output is not stalled. The exponential table is read at two addresses
// (entry and next entry) in the same stage with registered data. A stalled
// output holds its beat; empty stages still fill behind it, so the input
// stalls only when all 14 stages hold an item and the output is stalled.
// Registers may be written only while no beat is in flight.
`include "assert_macros.svh"

module morlet_wavelet_bin_generator #(
	parameter int INDEX_BITS      = mwbg_pkg::INDEX_BITS_DEFAULT,
	parameter int EXP_TABLE_DEPTH = mwbg_pkg::EXP_TABLE_DEPTH_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_write,
	input  logic [mwbg_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [mwbg_pkg::CFG_DATA_W-1:0]     cfg_data,
	// input channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [mwbg_pkg::BIN_W-1:0]          bin_index,
	// output channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [mwbg_pkg::BIN_W-1:0]          bin_echo,
	output logic [mwbg_pkg::VALUE_W-1:0]        wavelet_value,
	output logic signed [mwbg_pkg::DERIV_W-1:0] derivative_imag
);

	localparam int LAST  = 14;
	localparam int KW    = INDEX_BITS;
	localparam int WW    = KW + 32;
	localparam int WHW   = WW - 24;
	localparam int HPW   = WHW + 32;
	localparam int LPW   = 56;
	localparam int OMW   = KW + 40;
	localparam int OMHW  = OMW - 32;
	localparam int XIW   = KW + 36;
	localparam int HALFW = (KW > 16) ? KW : 16;
	localparam int AW    = $clog2(EXP_TABLE_DEPTH);
	localparam int RW    = $clog2(EXP_TABLE_DEPTH + 1);
	localparam int PW    = AW + 16;
	localparam int DSW   = 2 * mwbg_pkg::NEAR_BITS;
	localparam int DSSW  = DSW + RW;
	localparam int DHW   = OMHW + 32;
	localparam int PRW   = DHW + 33;
	localparam int MW    = PRW - 16;
	localparam int EW    = mwbg_pkg::EXP_W;
	localparam int SLW   = EW + 16;
	localparam int NPW   = EW + 32;
	localparam int VW    = mwbg_pkg::VALUE_W;
	localparam int BW    = mwbg_pkg::BIN_W;
	localparam int NB    = mwbg_pkg::NEAR_BITS;

	// configuration registers
	logic [mwbg_pkg::LENGTH_W-1:0] length_q;
	logic [mwbg_pkg::STEP_W-1:0]   step_q;
	logic [mwbg_pkg::SCALE_W-1:0]  scale_q;
	logic [mwbg_pkg::OMEGA_W-1:0]  center_q;
	logic [mwbg_pkg::NORM_W-1:0]   norm_q;
	logic [mwbg_pkg::PHYS_W-1:0]   phys_q;

	// register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= mwbg_pkg::LENGTH_RESET;
			step_q   <= mwbg_pkg::STEP_RESET;
			scale_q  <= mwbg_pkg::SCALE_RESET;
			center_q <= mwbg_pkg::OMEGA_RESET;
			norm_q   <= mwbg_pkg::NORM_RESET;
			phys_q   <= mwbg_pkg::PHYS_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				mwbg_pkg::REG_LENGTH_N:     length_q <= cfg_data[mwbg_pkg::LENGTH_W-1:0];
				mwbg_pkg::REG_BIN_STEP:     step_q   <= cfg_data[mwbg_pkg::STEP_W-1:0];
				mwbg_pkg::REG_SCALE_VALUE:  scale_q  <= cfg_data[mwbg_pkg::SCALE_W-1:0];
				mwbg_pkg::REG_CENTER_OMEGA: center_q <= cfg_data[mwbg_pkg::OMEGA_W-1:0];
				mwbg_pkg::REG_NORM_GAIN:    norm_q   <= cfg_data[mwbg_pkg::NORM_W-1:0];
				mwbg_pkg::REG_PHYS_STEP:    phys_q   <= cfg_data[mwbg_pkg::PHYS_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline flow control: a stage loads when empty or when the next one loads
	logic [LAST:1] pipe_valid_q;
	logic [LAST:1] advance;
	logic [LAST:1] feed_valid;

	assign advance[LAST]    = !pipe_valid_q[LAST] || !out_stall;
	assign feed_valid[1]    = in_valid;
	for (genvar gs = 1; gs < LAST; gs++) begin : g_flow
		assign advance[gs]        = !pipe_valid_q[gs] || advance[gs+1];
		assign feed_valid[gs + 1] = pipe_valid_q[gs];
	end

	assign in_stall  = !advance[1];
	assign out_valid = pipe_valid_q[LAST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pipe_valid_q <= '0;
		end else begin
			for (int i = 1; i <= LAST; i++) begin
				if (advance[i]) begin
					pipe_valid_q[i] <= feed_valid[i];
				end
			end
		end
	end

	// exponential table, exp(-32*i/depth) in q0.32
	logic [EW-1:0] exp_rom [EXP_TABLE_DEPTH+1];
	for (genvar gi = 0; gi <= EXP_TABLE_DEPTH; gi++) begin : g_rom
		localparam logic [127:0] ROM_ARG = (128'(gi) << 59) / 128'(EXP_TABLE_DEPTH);
		assign exp_rom[gi] = mwbg_pkg::exp_rom_entry(ROM_ARG[63:0]);
	end

	// stage 1: bin decode, angular step products
	logic [KW-1:0]    k_in;
	logic [HALFW-1:0] k_cmp;
	logic [HALFW-1:0] half_cmp;
	logic             pos_in;
	logic [BW-1:0]    echo_s1;
	logic             pos_s1;
	logic [WW-1:0]    w_s1;
	logic [WW-1:0]    om_lo_s1;
	logic [KW+7:0]    om_hi_s1;

	assign k_in     = KW'(bin_index);
	assign k_cmp    = HALFW'(k_in);
	assign half_cmp = HALFW'(length_q[mwbg_pkg::LENGTH_W-1:1]);
	assign pos_in   = (k_in != '0) && (k_cmp <= half_cmp);

	always_ff @(posedge clk) begin
		if (advance[1]) begin
			echo_s1  <= BW'(k_in);
			pos_s1   <= pos_in;
			w_s1     <= WW'(k_in) * WW'(step_q);
			om_lo_s1 <= WW'(k_in) * WW'(phys_q[31:0]);
			om_hi_s1 <= (KW + 8)'(k_in) * (KW + 8)'(phys_q[mwbg_pkg::PHYS_W-1:32]);
		end
	end

	// stage 2: scale times angular step, split in two products
	logic [BW-1:0]  echo_s2;
	logic           pos_s2;
	logic [HPW-1:0] hp_s2;
	logic [LPW-1:0] lp_s2;
	logic [OMW-1:0] om_s2;

	always_ff @(posedge clk) begin
		if (advance[2]) begin
			echo_s2 <= echo_s1;
			pos_s2  <= pos_s1;
			hp_s2   <= HPW'(scale_q) * HPW'(w_s1[WW-1:24]);
			lp_s2   <= LPW'(scale_q) * LPW'(w_s1[23:0]);
			om_s2   <= (OMW'(om_hi_s1) << 32) + OMW'(om_lo_s1);
		end
	end

	// stage 3: scaled frequency xi in q.16, rounded
	logic [56:0]    xi_low_sum;
	logic [BW-1:0]  echo_s3;
	logic           pos_s3;
	logic [XIW-1:0] xi_s3;
	logic [OMW-1:0] om_s3;

	assign xi_low_sum = {28'd0, hp_s2[4:0], 24'd0} + {1'b0, lp_s2} + (57'd1 << 28);

	always_ff @(posedge clk) begin
		if (advance[3]) begin
			echo_s3 <= echo_s2;
			pos_s3  <= pos_s2;
			xi_s3   <= XIW'(hp_s2 >> 5) + XIW'(xi_low_sum >> 29);
			om_s3   <= om_s2;
		end
	end

	// stage 4: distance from center frequency
	logic [XIW-1:0] center_ext;
	logic [XIW-1:0] dist_full;
	logic [BW-1:0]  echo_s4;
	logic           pos_s4;
	logic           near_s4;
	logic [NB-1:0]  d_s4;
	logic [OMW-1:0] om_s4;

	assign center_ext = XIW'(center_q);
	assign dist_full  = (xi_s3 >= center_ext) ? (xi_s3 - center_ext) : (center_ext - xi_s3);

	always_ff @(posedge clk) begin
		if (advance[4]) begin
			echo_s4 <= echo_s3;
			pos_s4  <= pos_s3;
			near_s4 <= (dist_full >> NB) == '0;
			d_s4    <= dist_full[NB-1:0];
			om_s4   <= om_s3;
		end
	end

	// stage 5: squared distance
	logic [BW-1:0]  echo_s5;
	logic           pos_s5;
	logic           near_s5;
	logic [DSW-1:0] dsq_s5;
	logic [OMW-1:0] om_s5;

	always_ff @(posedge clk) begin
		if (advance[5]) begin
			echo_s5 <= echo_s4;
			pos_s5  <= pos_s4;
			near_s5 <= near_s4;
			dsq_s5  <= DSW'(d_s4) * DSW'(d_s4);
			om_s5   <= om_s4;
		end
	end

	// stage 6: table position, integer index and 16 bit fraction
	logic [DSSW-1:0] dsq_scaled;
	logic [BW-1:0]   echo_s6;
	logic            pos_s6;
	logic            near_s6;
	logic [AW-1:0]   j_s6;
	logic [15:0]     f_s6;
	logic [OMW-1:0]  om_s6;

	assign dsq_scaled = DSSW'(dsq_s5) * DSSW'(EXP_TABLE_DEPTH);

	always_ff @(posedge clk) begin
		if (advance[6]) begin
			echo_s6 <= echo_s5;
			pos_s6  <= pos_s5;
			near_s6 <= near_s5;
			j_s6    <= dsq_scaled[22+PW-1:22+16];
			f_s6    <= dsq_scaled[22+15:22];
			om_s6   <= om_s5;
		end
	end

	// stage 7: table read at the entry and the next entry
	logic [RW-1:0]  rom_addr0;
	logic [RW-1:0]  rom_addr1;
	logic [BW-1:0]  echo_s7;
	logic           pos_s7;
	logic           near_s7;
	logic [EW-1:0]  t0_s7;
	logic [EW-1:0]  t1_s7;
	logic [15:0]    f_s7;
	logic [OMW-1:0] om_s7;

	assign rom_addr0 = RW'(j_s6);
	assign rom_addr1 = rom_addr0 + RW'(1);

	always_ff @(posedge clk) begin
		if (advance[7]) begin
			echo_s7 <= echo_s6;
			pos_s7  <= pos_s6;
			near_s7 <= near_s6;
			t0_s7   <= exp_rom[rom_addr0];
			t1_s7   <= exp_rom[rom_addr1];
			f_s7    <= f_s6;
			om_s7   <= om_s6;
		end
	end

	// stage 8: interpolation slope times fraction
	logic [EW-1:0]  seg_diff;
	logic [BW-1:0]  echo_s8;
	logic           pos_s8;
	logic           near_s8;
	logic [EW-1:0]  t0_s8;
	logic [SLW-1:0] slope_s8;
	logic [OMW-1:0] om_s8;

	assign seg_diff = (t0_s7 > t1_s7) ? (t0_s7 - t1_s7) : '0;

	always_ff @(posedge clk) begin
		if (advance[8]) begin
			echo_s8  <= echo_s7;
			pos_s8   <= pos_s7;
			near_s8  <= near_s7;
			t0_s8    <= t0_s7;
			slope_s8 <= SLW'(seg_diff) * SLW'(f_s7);
			om_s8    <= om_s7;
		end
	end

	// stage 9: interpolated exponential, zero far from center
	logic [SLW-1:0] slope_rnd;
	logic [EW-1:0]  exp_val;
	logic [BW-1:0]  echo_s9;
	logic           pos_s9;
	logic [EW-1:0]  e_s9;
	logic [OMW-1:0] om_s9;

	assign slope_rnd = slope_s8 + SLW'(1 << 15);
	assign exp_val   = t0_s8 - EW'(slope_rnd >> 16);

	always_ff @(posedge clk) begin
		if (advance[9]) begin
			echo_s9 <= echo_s8;
			pos_s9  <= pos_s8;
			e_s9    <= near_s8 ? exp_val : '0;
			om_s9   <= om_s8;
		end
	end

	// stage 10: gain times exponential
	logic [BW-1:0]  echo_s10;
	logic           pos_s10;
	logic [NPW-1:0] nprod_s10;
	logic [OMW-1:0] om_s10;

	always_ff @(posedge clk) begin
		if (advance[10]) begin
			echo_s10  <= echo_s9;
			pos_s10   <= pos_s9;
			nprod_s10 <= NPW'(norm_q) * NPW'(e_s9);
			om_s10    <= om_s9;
		end
	end

	// stage 11: wavelet value rounded to q16.16, zero outside positive bins
	logic [NPW-1:0] nprod_rnd;
	logic [BW-1:0]  echo_s11;
	logic [VW-1:0]  val_s11;
	logic [OMW-1:0] om_s11;

	assign nprod_rnd = nprod_s10 + (NPW'(1) << 31);

	always_ff @(posedge clk) begin
		if (advance[11]) begin
			echo_s11 <= echo_s10;
			val_s11  <= pos_s10 ? nprod_rnd[63:32] : '0;
			om_s11   <= om_s10;
		end
	end

	// stage 12: physical frequency times value, split in two products
	logic [BW-1:0]  echo_s12;
	logic [VW-1:0]  val_s12;
	logic [DHW-1:0] dhi_s12;
	logic [63:0]    dlo_s12;

	always_ff @(posedge clk) begin
		if (advance[12]) begin
			echo_s12 <= echo_s11;
			val_s12  <= val_s11;
			dhi_s12  <= DHW'(val_s11) * DHW'(om_s11[OMW-1:32]);
			dlo_s12  <= 64'(val_s11) * 64'(om_s11[31:0]);
		end
	end

	// stage 13: full product with rounding offset
	logic [BW-1:0]  echo_s13;
	logic [VW-1:0]  val_s13;
	logic [PRW-1:0] prod_s13;

	always_ff @(posedge clk) begin
		if (advance[13]) begin
			echo_s13 <= echo_s12;
			val_s13  <= val_s12;
			prod_s13 <= (PRW'(dhi_s12) << 32) + PRW'(dlo_s12) + PRW'(1 << 15);
		end
	end

	// stage 14: saturate and negate, output beat
	logic [MW-1:0]                 deriv_mag;
	logic [mwbg_pkg::DERIV_W-1:0]  deriv_sat;
	logic [BW-1:0]                 echo_s14;
	logic [VW-1:0]                 val_s14;
	logic [mwbg_pkg::DERIV_W-1:0]  deriv_s14;

	assign deriv_mag = prod_s13[PRW-1:16];
	assign deriv_sat = (deriv_mag > MW'(mwbg_pkg::DERIV_LIMIT)) ?
		mwbg_pkg::DERIV_LIMIT : deriv_mag[mwbg_pkg::DERIV_W-1:0];

	always_ff @(posedge clk) begin
		if (advance[14]) begin
			echo_s14  <= echo_s13;
			val_s14   <= val_s13;
			deriv_s14 <= '0 - deriv_sat;
		end
	end

	assign bin_echo        = echo_s14;
	assign wavelet_value   = val_s14;
	assign derivative_imag = deriv_s14;

	// checks
	`ASSERT_CLK(a_zero_value_zero_deriv, clk, arst_n,
		out_valid && (wavelet_value == '0) |-> derivative_imag == '0,
		"zero wavelet value with nonzero derivative")
	`ASSERT_CLK(a_deriv_not_positive, clk, arst_n,
		out_valid |-> derivative_imag[mwbg_pkg::DERIV_W-1] || (derivative_imag == '0),
		"positive derivative value")
	`ASSERT_CLK(a_bin_zero_gives_zero, clk, arst_n,
		out_valid && (bin_echo == '0) |-> wavelet_value == '0,
		"bin zero gave nonzero wavelet value")
	`ASSERT_CLK(a_stall_only_when_full, clk, arst_n,
		in_stall |-> out_valid && out_stall && (pipe_valid_q == '1),
		"input stalled with room in the pipeline")

endmodule

### sim/morlet_wavelet_bin_generator_tb.sv
// self-checking testbench for the morlet wavelet bin generator with a bit-exact predictor
`timescale 1ns / 100ps

module morlet_wavelet_bin_generator_tb;
	import mwbg_pkg::*;

	localparam int EXP_TABLE_DEPTH = EXP_TABLE_DEPTH_DEFAULT;
	localparam int PHASE_BINS      = 115;
	localparam int LONG_HOLD       = 150;
	localparam int DRAIN_CYCLES    = 20;

	// register indexes with no register behind them
	localparam logic [CFG_INDEX_W-1:0] SPARE_INDEX_LO = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] SPARE_INDEX_HI = 3'd7;

	typedef struct packed {
		logic [BIN_W-1:0]   echo;
		logic [VALUE_W-1:0] magnitude;
		logic [DERIV_W-1:0] deriv;
	} bin_result_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_write = 1'b0;
	logic [CFG_INDEX_W-1:0]      cfg_index = '0;
	logic [CFG_DATA_W-1:0]       cfg_data = '0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic [BIN_W-1:0]            bin_index = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic [BIN_W-1:0]            bin_echo;
	logic [VALUE_W-1:0]          wavelet_value;
	logic signed [DERIV_W-1:0]   derivative_imag;

	// predictor copy of the registers
	logic [63:0] cur_length = 64'(LENGTH_RESET);
	logic [63:0] cur_step   = 64'(STEP_RESET);
	logic [63:0] cur_scale  = 64'(SCALE_RESET);
	logic [63:0] cur_omega  = 64'(OMEGA_RESET);
	logic [63:0] cur_norm   = 64'(NORM_RESET);
	logic [63:0] cur_phys   = 64'(PHYS_RESET);

	// exp(-32*i/depth) in q0.32
	logic [63:0] exp_table [0:EXP_TABLE_DEPTH];

	logic [BIN_W-1:0] bin_queue[$];
	bin_result_t      expected_results[$];

	int mismatches = 0;
	int results_checked = 0;
	int nonzero_values = 0;
	int saturated_derivs = 0;
	int backpressure_cycles = 0;
	int settings_used = 0;
	int hold_requests = 0;
	int holds_served = 0;

	// sender burst state
	int burst_left = 1;
	int gap_left = 0;

	// receiver stall state
	int hold_left = 0;
	int segment_left = 0;
	int stall_pct = 0;

	morlet_wavelet_bin_generator #(
		.INDEX_BITS(INDEX_BITS_DEFAULT),
		.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.bin_index(bin_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.bin_echo(bin_echo),
		.wavelet_value(wavelet_value),
		.derivative_imag(derivative_imag)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// (a*b) >> 60 rounded half up, low 64 bits
	function automatic logic [63:0] round_mul60(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] prod;
		prod = 128'(a) * 128'(b) + (128'd1 << 59);
		return 64'(prod >> 60);
	endfunction

	// expected beat for one bin under the current register settings
	function automatic bin_result_t wavelet_at_bin(input logic [BIN_W-1:0] bin);
		logic [63:0]  k, w, xi, d, p, j, f, t0, t1, diff, e, val, om, m;
		logic [127:0] prod;
		bin_result_t  res;
		k = 64'(bin);
		val = '0;
		m = '0;
		if (k >= 1 && k <= (cur_length >> 1) && k < cur_length) begin
			w = k * cur_step;
			prod = 128'(cur_scale) * 128'(w) + (128'd1 << 28);
			xi = 64'(prod >> 29);
			d = (xi >= cur_omega) ? xi - cur_omega : cur_omega - xi;
			e = '0;
			// table lookup with linear interpolation, zero far from center
			if (d < (64'd8 << 16)) begin
				p = (d * d * 64'(EXP_TABLE_DEPTH)) >> 22;
				j = p >> 16;
				f = p & 64'hFFFF;
				if (j < 64'(EXP_TABLE_DEPTH)) begin
					t0 = exp_table[j];
					t1 = exp_table[j + 1];
					diff = (t0 > t1) ? t0 - t1 : 64'd0;
					e = t0 - ((diff * f + (64'd1 << 15)) >> 16);
				end
			end
			prod = 128'(cur_norm) * 128'(e) + (128'd1 << 31);
			val = 64'(prod >> 32);
			// derivative magnitude with saturation
			om = k * cur_phys;
			if (om != 0 && val != 0) begin
				prod = 128'(om) * 128'(val);
				if (prod > 128'(64'hFFFF_FFFF_FFFF_FFFF)) begin
					m = 64'(DERIV_LIMIT);
				end else begin
					m = 64'((prod + (128'd1 << 15)) >> 16);
					if (m > 64'(DERIV_LIMIT)) begin
						m = 64'(DERIV_LIMIT);
					end
				end
			end
		end
		res.echo = bin;
		res.magnitude = val[VALUE_W-1:0];
		res.deriv = DERIV_W'(64'd0 - m);
		return res;
	endfunction

	// junk above a register's width, dropped by the block
	function automatic logic [CFG_DATA_W-1:0] upper_noise(input int width);
		logic [63:0] noise;
		noise = {$urandom(), $urandom()};
		return CFG_DATA_W'(noise & ~((64'd1 << width) - 1));
	endfunction

	// one register write, mirrored into the predictor
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_LENGTH_N:     cur_length = 64'(data[LENGTH_W-1:0]);
			REG_BIN_STEP:     cur_step = 64'(data[STEP_W-1:0]);
			REG_SCALE_VALUE:  cur_scale = 64'(data[SCALE_W-1:0]);
			REG_CENTER_OMEGA: cur_omega = 64'(data[OMEGA_W-1:0]);
			REG_NORM_GAIN:    cur_norm = 64'(data[NORM_W-1:0]);
			REG_PHYS_STEP:    cur_phys = 64'(data[PHYS_W-1:0]);
			default: ;
		endcase
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic program_regs(
		input logic [LENGTH_W-1:0] len,
		input logic [STEP_W-1:0]   step,
		input logic [SCALE_W-1:0]  scale,
		input logic [OMEGA_W-1:0]  omega,
		input logic [NORM_W-1:0]   norm,
		input logic [PHYS_W-1:0]   phys,
		input bit                  dirty
	);
		write_reg(REG_LENGTH_N, CFG_DATA_W'(len) | (dirty ? upper_noise(LENGTH_W) : '0));
		write_reg(REG_BIN_STEP, CFG_DATA_W'(step) | (dirty ? upper_noise(STEP_W) : '0));
		write_reg(REG_SCALE_VALUE, CFG_DATA_W'(scale) | (dirty ? upper_noise(SCALE_W) : '0));
		write_reg(REG_CENTER_OMEGA, CFG_DATA_W'(omega) | (dirty ? upper_noise(OMEGA_W) : '0));
		write_reg(REG_NORM_GAIN, CFG_DATA_W'(norm) | (dirty ? upper_noise(NORM_W) : '0));
		write_reg(REG_PHYS_STEP, CFG_DATA_W'(phys));
		settings_used++;
	endtask

	// sender idle and every result back
	task automatic wait_drained();
		while (bin_queue.size() != 0 || in_valid || expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	// input driver: bursts with random gaps, stalled beats held
	always @(posedge clk) begin
		bin_result_t pred;
		logic [BIN_W-1:0] k;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				k = bin_queue.pop_front();
				pred = wavelet_at_bin(k);
				expected_results.push_back(pred);
			end
			if (in_valid && in_stall) begin
				backpressure_cycles++;
			end else if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (bin_queue.size() != 0) begin
				in_valid <= 1'b1;
				bin_index <= bin_queue[0];
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 32);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output monitor and receiver stall pattern
	always @(posedge clk) begin
		bin_result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("result beat for bin %0d with nothing expected", bin_echo);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					results_checked++;
					if (want.magnitude != 0) nonzero_values++;
					if (want.deriv == DERIV_LIMIT) saturated_derivs++;
					if (bin_echo !== want.echo) begin
						$error("bin_echo: expected %0d, got %0d", want.echo, bin_echo);
						mismatches++;
					end
					if (wavelet_value !== want.magnitude) begin
						$error("wavelet_value: expected %0d, got %0d", want.magnitude,
							wavelet_value);
						mismatches++;
					end
					if (derivative_imag !== want.deriv) begin
						$error("derivative_imag: expected %0d, got %0d", $signed(want.deriv),
							derivative_imag);
						mismatches++;
					end
				end
			end
			// long hold-off on request, otherwise random segments
			if (holds_served != hold_requests) begin
				holds_served++;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (segment_left <= 0) begin
					segment_left = $urandom_range(16, 96);
					case ($urandom_range(0, 4))
						0, 1: stall_pct = 0;
						2: stall_pct = 20;
						3: stall_pct = 50;
						default: stall_pct = 80;
					endcase
				end
				segment_left--;
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	// stimulus
	initial begin
		int phase, n, kc, len, k;
		logic [63:0] y, q, r, sum, term, wide;
		real scale_r;
		logic [STEP_W-1:0]  step;
		logic [SCALE_W-1:0] scale;
		logic [OMEGA_W-1:0] omega;
		logic [NORM_W-1:0]  norm;
		logic [PHYS_W-1:0]  phys;

		// exponential table: taylor series of exp(-x/64), squared six times
		q = (64'd1 << 59) / 64'(EXP_TABLE_DEPTH);
		r = (64'd1 << 59) % 64'(EXP_TABLE_DEPTH);
		for (int i = 0; i <= EXP_TABLE_DEPTH; i++) begin
			y = 64'(i) * q + (64'(i) * r) / 64'(EXP_TABLE_DEPTH);
			sum = 64'd1 << 60;
			term = 64'd1 << 60;
			for (int t = 1; t <= 24; t++) begin
				term = round_mul60(term, y) / 64'(t);
				if (t % 2 == 1) sum = sum - term;
				else sum = sum + term;
			end
			for (int t = 0; t < 6; t++) begin
				sum = round_mul60(sum, sum);
			end
			exp_table[i] = (sum + (64'd1 << 27)) >> 28;
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: zero bin, edges of the positive half, out of range
		settings_used++;
		bin_queue.push_back(16'd0);
		bin_queue.push_back(16'd1);
		bin_queue.push_back(16'd512);
		bin_queue.push_back(16'd513);
		bin_queue.push_back(16'd1024);
		bin_queue.push_back(16'hFFFF);
		wait_drained();

		// center hit with full gain, derivative saturates
		program_regs(17'd256, 32'd13176795, 32'd250329, 24'(6 << 16), '1, '1, 1'b0);
		bin_queue.push_back(16'd64);
		bin_queue.push_back(16'd63);
		bin_queue.push_back(16'd65);
		bin_queue.push_back(16'd128);
		bin_queue.push_back(16'd129);
		wait_drained();

		// shortest transform
		write_reg(REG_LENGTH_N, 40'd2);
		bin_queue.push_back(16'd1);
		bin_queue.push_back(16'd2);
		wait_drained();

		// length below two, then writes to unmapped indexes that must change nothing
		write_reg(REG_LENGTH_N, 40'd0);
		write_reg(SPARE_INDEX_LO, CFG_DATA_W'({$urandom(), $urandom()}));
		write_reg(SPARE_INDEX_HI, CFG_DATA_W'({$urandom(), $urandom()}));
		bin_queue.push_back(16'd1);
		wait_drained();

		// longest transform with zero scale, every bin at the same distance from center
		write_reg(REG_LENGTH_N, 40'd65536);
		write_reg(REG_SCALE_VALUE, 40'd0);
		write_reg(REG_CENTER_OMEGA, 40'(3 << 16));
		bin_queue.push_back(16'd32768);
		bin_queue.push_back(16'd32769);
		bin_queue.push_back(16'hFFFF);
		wait_drained();

		// random phases, each with its own register setting
		for (phase = 0; phase < 8; phase++) begin
			case (phase)
				0: begin
					len = 65536;
					step = '1;
					scale = '1;
					omega = '1;
					norm = '1;
					phys = '1;
				end
				1: begin
					len = 1024;
					step = '0;
					scale = $urandom();
					omega = 24'(2 << 16);
					norm = '1;
					phys = '1;
				end
				default: begin
					case ($urandom_range(0, 4))
						0: len = $urandom_range(2, 8);
						1: len = 1 << $urandom_range(2, 16);
						2: len = $urandom_range(2, 65536);
						3: len = 65536;
						default: len = 1 << $urandom_range(6, 12);
					endcase
					if ($urandom_range(0, 4) != 0) begin
						scale_r = 6.283185307179586 / real'(len) * 536870912.0;
						if (scale_r > 4294967295.0) scale_r = 4294967295.0;
						wide = scale_r;
						step = wide[STEP_W-1:0];
					end else begin
						step = $urandom();
					end
					case ($urandom_range(0, 9))
						0: omega = '0;
						1: omega = '1;
						2, 3: omega = OMEGA_W'($urandom());
						default: omega = OMEGA_W'($urandom_range(1 << 16, 12 << 16));
					endcase
					norm = ($urandom_range(0, 5) == 0) ? '0 : $urandom();
					phys = PHYS_W'({$urandom(), $urandom()});
					phys = phys >> $urandom_range(0, 39);
				end
			endcase
			kc = $urandom_range(1, (len / 2 > 1) ? len / 2 : 1);
			// scale that puts omega0 near bin kc
			if (phase > 1 && step != 0 && $urandom_range(0, 6) != 0) begin
				scale_r = (real'(omega) / 65536.0) / (real'(kc) * real'(step) / 536870912.0)
					* 65536.0;
				if (scale_r > 4294967295.0) scale_r = 4294967295.0;
				wide = scale_r;
				scale = wide[SCALE_W-1:0];
			end else if (phase > 1) begin
				scale = $urandom();
			end
			program_regs(LENGTH_W'(len), step, scale, omega, norm, phys,
				$urandom_range(0, 3) == 0);

			for (n = 0; n < PHASE_BINS; n++) begin
				// sender pause until every result is back
				if (phase == 5 && n == PHASE_BINS / 2) wait_drained();
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: begin
						k = kc + $urandom_range(0, 96) - 48;
						if (k < 0) k = -k;
					end
					6, 7: k = $urandom_range(0, (len < 65535) ? len : 65535);
					8: begin
						case ($urandom_range(0, 5))
							0: k = 0;
							1: k = 1;
							2: k = len / 2;
							3: k = len / 2 + 1;
							4: k = len - 1;
							default: k = len;
						endcase
					end
					default: k = $urandom_range(0, 65535);
				endcase
				bin_queue.push_back(BIN_W'(k));
			end
			// receiver holds off while the whole phase is offered
			if (phase == 3) hold_requests++;
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d expected results never arrived", expected_results.size());
			mismatches++;
		end
		$display("checked %0d result beats across %0d register settings (%0d nonzero, %0d saturated)",
			results_checked, settings_used, nonzero_values, saturated_derivs);
		$display("input held off for %0d cycles with a beat waiting; %0d mismatches",
			backpressure_cycles, mismatches);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
